/* rtl/assert_macros.svh */
// assertion macros shared by the keypad debounce rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define KDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/kde_pkg.sv */
// types and constants for the keypad debounce event engine
// no dependencies; imported by the interfaces and by every module but kde_ram
package kde_pkg;

    localparam int NUM_KEYS_DEF   = 29;
    localparam int FIFO_DEPTH_DEF = 4;
    localparam int RAW_W          = 29;
    localparam int TIME_W         = 32;
    localparam int KEY_W          = 5;
    localparam int DEB_W          = 8;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd1;
    localparam logic [DEB_W-1:0] DEBOUNCE_MIN   = 8'd1;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } t_walk_state;

    localparam logic EV_PRESSED  = 1'b0;
    localparam logic EV_RELEASED = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             new_state;
        logic             last_event;
    } t_event;

endpackage

/* rtl/kde_snap_if.sv */
// snapshot channel: valid/ready plus raw bitmap and timestamp
// depends on kde_pkg
interface kde_snap_if
    import kde_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RAW_W-1:0]  raw_pressed;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output raw_pressed, output now_time, input ready);
    modport sink   (input valid, input raw_pressed, input now_time, output ready);
endinterface

/* rtl/kde_event_if.sv */
// event channel: valid/ready plus key number, new state and last marker
// depends on kde_pkg
interface kde_event_if
    import kde_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_index;
    logic             new_state;
    logic             last_event;

    modport source (output valid, output key_index, output new_state, output last_event,
                    input ready);
    modport sink   (input valid, input key_index, input new_state, input last_event,
                    output ready);
endinterface

/* rtl/keypad_debounce_event_engine.sv */
// Keypad debounce event engine. Each accepted snapshot (raw key bitmap plus a
// millisecond timestamp) is walked one key per cycle over the per-key
// start-time ram, holding only while the event queue is full, then a flush
// step ends it; the next snapshot is taken only once walk and flush are done.
// Events leave in key order, one per word, the last of a snapshot marked by
// last_event; a snapshot with no events produces no words.
// depends on kde_pkg, kde_snap_if, kde_event_if, kde_front, kde_fifo, kde_back
module keypad_debounce_event_engine
    import kde_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kde_snap_if.sink         i_snap,
    kde_event_if.source      o_event,
    input  logic             i_cfg_we,
    input  logic [DEB_W-1:0] i_cfg_wdata
);
    logic   push, pop, full, empty;
    t_event push_data, pop_data;

    kde_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap      (i_snap),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    kde_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_full  (full),
        .o_empty (empty)
    );

    kde_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (pop_data),
        .i_empty (empty),
        .o_pop   (pop),
        .o_event (o_event)
    );
endmodule

/* rtl/kde_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module kde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/kde_fifo.sv */
// short event queue between the key walker and the output stage
// depends on kde_pkg and assert_macros.svh
`include "assert_macros.svh"
module kde_fifo
    import kde_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    input  logic   i_pop,
    output t_event o_data,
    output logic   o_full,
    output logic   o_empty
);
    t_event        r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [PW:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);

    `KDE_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full || i_pop)
    `KDE_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
endmodule

/* rtl/kde_front.sv */
// key walker: takes a snapshot, debounces one key per cycle unless stalled by a full queue, queues events
// depends on kde_pkg, kde_snap_if, kde_ram and assert_macros.svh
`include "assert_macros.svh"
module kde_front
    import kde_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF,
    localparam int KW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kde_snap_if.sink         i_snap,
    input  logic             i_cfg_we,
    input  logic [DEB_W-1:0] i_cfg_wdata,
    input  logic             i_full,
    output logic             o_push,
    output t_event           o_push_data
);
    t_walk_state        r_state, n_state;
    logic [KW-1:0]      r_key, n_key;
    logic [RAW_W-1:0]   r_raw;
    logic [TIME_W-1:0]  r_now;
    logic [DEB_W-1:0]   r_deb;
    logic [NUM_KEYS-1:0] r_stable;
    logic [NUM_KEYS-1:0] r_pend;
    t_phase             r_phase [NUM_KEYS];
    t_event             r_hold;
    logic               r_hold_vld;

    logic [RAW_W+NUM_KEYS-1:0] raw_ext;
    logic [KEY_W+KW-1:0]       key_ext;
    logic [TIME_W-1:0]         start_time;
    logic [TIME_W-1:0]         elapsed;
    logic                      lvl, stab, pend, differ, toggle;
    logic                      new_stab, new_pend, wr_start;
    t_phase                    new_phase;
    logic                      ev_vld, ev_state;
    logic                      last_key, stall, step;

    assign raw_ext = {{NUM_KEYS{1'b0}}, r_raw};
    assign key_ext = {{KEY_W{1'b0}}, r_key};
    assign lvl     = raw_ext[r_key];
    assign stab    = r_stable[r_key];
    assign pend    = r_pend[r_key];
    assign differ  = (lvl != stab);
    assign elapsed = r_now - start_time;
    assign toggle  = differ && pend && (elapsed >= TIME_W'(r_deb));
    assign new_stab = stab ^ toggle;
    assign new_pend = differ && !toggle;
    assign wr_start = differ && !pend;
    assign last_key = (r_key == KW'(NUM_KEYS - 1));

    always_comb begin
        new_phase = PH_IDLE;
        ev_vld    = 1'b0;
        ev_state  = EV_PRESSED;
        case (r_phase[r_key])
            PH_IDLE: begin
                if (new_stab) begin
                    new_phase = PH_PRESSED;
                    ev_vld    = 1'b1;
                    ev_state  = EV_PRESSED;
                end
            end
            PH_PRESSED: begin
                new_phase = PH_PRESSED;
                if (!new_stab) begin
                    new_phase = PH_RELEASED;
                    ev_vld    = 1'b1;
                    ev_state  = EV_RELEASED;
                end
            end
            default: begin
                new_phase = PH_IDLE;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_snap.valid) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!stall && last_key) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_snap.ready = 1'b0;
        stall        = 1'b0;
        step         = 1'b0;
        o_push       = 1'b0;
        o_push_data  = '{key_index: r_hold.key_index, new_state: r_hold.new_state,
                         last_event: 1'b0};
        case (r_state)
            S_IDLE: begin
                i_snap.ready = 1'b1;
            end
            S_WALK: begin
                stall  = ev_vld && r_hold_vld && i_full;
                step   = !stall;
                o_push = ev_vld && r_hold_vld && !i_full;
            end
            S_FLUSH: begin
                stall  = r_hold_vld && i_full;
                o_push = r_hold_vld && !i_full;
                o_push_data.last_event = 1'b1;
            end
            default: begin
                i_snap.ready = 1'b0;
            end
        endcase
    end

    assign n_key = (step && !last_key) ? r_key + 1'b1 : (step ? '0 : r_key);

    kde_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_KEYS)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (step && wr_start),
        .i_waddr (r_key),
        .i_wdata (r_now),
        .i_raddr (n_key),
        .o_rdata (start_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_key      <= '0;
            r_deb      <= DEBOUNCE_RESET;
            r_stable   <= '0;
            r_pend     <= '0;
            r_hold_vld <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_phase[i] <= PH_IDLE;
            end
        end else begin
            r_state <= n_state;
            r_key   <= n_key;
            if (i_cfg_we) begin
                r_deb <= (i_cfg_wdata == '0) ? DEBOUNCE_MIN : i_cfg_wdata;
            end
            if (step) begin
                r_stable[r_key] <= new_stab;
                r_pend[r_key]   <= new_pend;
                r_phase[r_key]  <= new_phase;
                if (ev_vld) begin
                    r_hold_vld <= 1'b1;
                end
            end
            if (r_state == S_FLUSH && !stall) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_snap.valid) begin
            r_raw <= i_snap.raw_pressed;
            r_now <= i_snap.now_time;
        end
        if (step && ev_vld) begin
            r_hold.key_index  <= key_ext[KEY_W-1:0];
            r_hold.new_state  <= ev_state;
            r_hold.last_event <= 1'b0;
        end
    end

    `KDE_ASSERT_IMP(a_idle_no_hold, i_clk, i_rst_n, r_state == S_IDLE, !r_hold_vld)
    `KDE_ASSERT_NXT(a_walk_adv, i_clk, i_rst_n, step && !last_key, r_key == $past(r_key) + 1'b1)
endmodule

/* rtl/kde_back.sv */
// output stage: drains the event queue into a registered event word
// depends on kde_pkg and kde_event_if
module kde_back
    import kde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_event     i_data,
    input  logic       i_empty,
    output logic       o_pop,
    kde_event_if.source o_event
);
    logic   r_vld;
    t_event r_data;

    assign o_pop = !i_empty && (!r_vld || o_event.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_pop) begin
            r_vld <= 1'b1;
        end else if (o_event.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    assign o_event.valid      = r_vld;
    assign o_event.key_index  = r_data.key_index;
    assign o_event.new_state  = r_data.new_state;
    assign o_event.last_event = r_data.last_event;
endmodule
